// ===== rtl/core/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants of the JSON string unescaper
// Holds the channel payload types, the record that travels from the parser
// to the result serializer, the status codes and the parser mode type.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // One byte of the string body and its end-of-buffer mark.
   typedef struct packed {
      logic [7:0] byte_in;
      logic       final_byte;
   } req_type;

   // One result: a decoded byte or a status.
   typedef struct packed {
      logic [7:0] out_byte;
      logic [3:0] status;
      logic       run_last;
   } rsp_type;

   // All results caused by one input byte: an optional code point, sent as
   // its UTF-8 bytes, followed by an optional status.
   typedef struct packed {
      logic        has_cp;
      logic [20:0] cp;
      logic        has_st;
      logic [3:0]  st;
   } run_type;

   typedef enum logic [2:0] {
      MODE_PLAIN,
      MODE_ESC,
      MODE_HEX_HI,
      MODE_LOW_BS,
      MODE_LOW_U,
      MODE_HEX_LO,
      MODE_UTF8,
      MODE_DONE
   } mode_type;

   localparam logic [3:0] ST_BYTE       = 4'd0;
   localparam logic [3:0] ST_CLOSED     = 4'd1;
   localparam logic [3:0] ST_CONTROL    = 4'd2;
   localparam logic [3:0] ST_BAD_UTF8   = 4'd3;
   localparam logic [3:0] ST_SHORT_UTF8 = 4'd4;
   localparam logic [3:0] ST_SHORT_ESC  = 4'd5;
   localparam logic [3:0] ST_SHORT_HEX  = 4'd6;
   localparam logic [3:0] ST_BAD_HEX    = 4'd7;
   localparam logic [3:0] ST_NO_LOW     = 4'd8;
   localparam logic [3:0] ST_BAD_LOW    = 4'd9;
   localparam logic [3:0] ST_LONE_LOW   = 4'd10;
   localparam logic [3:0] ST_BAD_ESC    = 4'd11;
   localparam logic [3:0] ST_UNTERM     = 4'd12;

endpackage

// ===== rtl/core/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front: string body parser
// Tracks escapes, hex digits and raw UTF-8 sequences one byte per cycle while
// accept is high; hands the results of each byte to the run queue as one record.
// ----------------------------------------------------------------------------
module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  jsu_pkg::req_type req_payload,
   output logic             run_valid,
   output jsu_pkg::run_type run_data
);
   import jsu_pkg::*;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6e;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;

   // Returns {bad, value}; a byte that is no hex digit has bad set and value 0.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b0, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b0, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   mode_type    mode_ff, mode_in;
   logic [2:0]  pend_ff, pend_in;
   logic [20:0] acc_ff, acc_in;
   logic [9:0]  high_ff, high_in;
   logic [1:0]  lead_ff, lead_in;
   logic        bad_ff, bad_in;

   logic [7:0]  b;
   logic        fin;
   logic [4:0]  hex;
   logic [15:0] hex_acc;
   logic [20:0] utf_acc;
   logic [2:0]  pend_inc;
   logic        bad_utf, bad_hexd;
   logic [20:0] utf_min;
   logic        emit, fail, term;
   logic [3:0]  fail_st;
   logic [20:0] cp;

   always_comb begin
      b        = req_payload.byte_in;
      fin      = req_payload.final_byte;
      hex      = hex_value(b);
      hex_acc  = {acc_ff[11:0], hex[3:0]};
      utf_acc  = {acc_ff[14:0], b[5:0]};
      pend_inc = pend_ff + 3'd1;
      bad_utf  = bad_ff | (b[7:6] != 2'b10);
      bad_hexd = bad_ff | hex[4];
      case (lead_ff)
         2'd1:    utf_min = 21'h00080;
         2'd2:    utf_min = 21'h00800;
         default: utf_min = 21'h10000;
      endcase

      mode_in = mode_ff;
      pend_in = pend_ff;
      acc_in  = acc_ff;
      high_in = high_ff;
      lead_in = lead_ff;
      bad_in  = bad_ff;
      emit    = 1'b0;
      cp      = '0;
      fail    = 1'b0;
      fail_st = ST_BYTE;

      case (mode_ff)
         MODE_PLAIN: begin
            if (b == CH_QUOTE) begin
               fail = 1'b1; fail_st = ST_CLOSED;
            end else if (b < 8'h20) begin
               fail = 1'b1; fail_st = ST_CONTROL;
            end else if (b == CH_BSLASH) begin
               if (fin) begin
                  fail = 1'b1; fail_st = ST_SHORT_ESC;
               end else begin
                  mode_in = MODE_ESC;
               end
            end else if (b < 8'h80) begin
               emit = 1'b1;
               cp   = {13'd0, b};
            end else if (b < 8'hc2 || b > 8'hf4) begin
               fail = 1'b1; fail_st = ST_BAD_UTF8;
            end else begin
               if (b <= 8'hdf) begin
                  lead_in = 2'd1;
                  acc_in  = {16'd0, b[4:0]};
               end else if (b <= 8'hef) begin
                  lead_in = 2'd2;
                  acc_in  = {17'd0, b[3:0]};
               end else begin
                  lead_in = 2'd3;
                  acc_in  = {18'd0, b[2:0]};
               end
               pend_in = '0;
               bad_in  = 1'b0;
               if (fin) begin
                  fail = 1'b1; fail_st = ST_SHORT_UTF8;
               end else begin
                  mode_in = MODE_UTF8;
               end
            end
         end
         MODE_UTF8: begin
            acc_in  = utf_acc;
            bad_in  = bad_utf;
            pend_in = pend_inc;
            if (pend_inc < {1'b0, lead_ff}) begin
               if (fin) begin
                  fail = 1'b1; fail_st = ST_SHORT_UTF8;
               end
            end else if (bad_utf || utf_acc < utf_min || utf_acc > 21'h10ffff ||
                         (utf_acc >= 21'h0d800 && utf_acc <= 21'h0dfff)) begin
               fail = 1'b1; fail_st = ST_BAD_UTF8;
            end else begin
               emit    = 1'b1;
               cp      = utf_acc;
               mode_in = MODE_PLAIN;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_PLAIN;
            case (b)
               CH_QUOTE, CH_BSLASH, CH_SLASH: begin
                  emit = 1'b1; cp = {13'd0, b};
               end
               CH_B: begin emit = 1'b1; cp = 21'h08; end
               CH_F: begin emit = 1'b1; cp = 21'h0c; end
               CH_N: begin emit = 1'b1; cp = 21'h0a; end
               CH_R: begin emit = 1'b1; cp = 21'h0d; end
               CH_T: begin emit = 1'b1; cp = 21'h09; end
               CH_U: begin
                  pend_in = '0;
                  acc_in  = '0;
                  bad_in  = 1'b0;
                  if (fin) begin
                     fail = 1'b1; fail_st = ST_SHORT_HEX;
                  end else begin
                     mode_in = MODE_HEX_HI;
                  end
               end
               default: begin
                  fail = 1'b1; fail_st = ST_BAD_ESC;
               end
            endcase
         end
         MODE_HEX_HI, MODE_HEX_LO: begin
            acc_in  = {5'd0, hex_acc};
            bad_in  = bad_hexd;
            pend_in = pend_inc;
            if (pend_inc < 3'd4) begin
               if (fin) begin
                  fail    = 1'b1;
                  fail_st = (mode_ff == MODE_HEX_HI) ? ST_SHORT_HEX : ST_NO_LOW;
               end
            end else if (bad_hexd) begin
               fail = 1'b1; fail_st = ST_BAD_HEX;
            end else if (mode_ff == MODE_HEX_HI) begin
               if (hex_acc >= 16'hd800 && hex_acc <= 16'hdbff) begin
                  high_in = hex_acc[9:0];
                  if (fin) begin
                     fail = 1'b1; fail_st = ST_NO_LOW;
                  end else begin
                     mode_in = MODE_LOW_BS;
                  end
               end else if (hex_acc >= 16'hdc00 && hex_acc <= 16'hdfff) begin
                  fail = 1'b1; fail_st = ST_LONE_LOW;
               end else begin
                  emit    = 1'b1;
                  cp      = {5'd0, hex_acc};
                  mode_in = MODE_PLAIN;
               end
            end else begin
               if (hex_acc < 16'hdc00 || hex_acc > 16'hdfff) begin
                  fail = 1'b1; fail_st = ST_BAD_LOW;
               end else begin
                  // 0x10000 + (high << 10) + low half, as one narrow add
                  emit    = 1'b1;
                  cp      = {11'({1'b0, high_ff} + 11'h040), hex_acc[9:0]};
                  mode_in = MODE_PLAIN;
               end
            end
         end
         MODE_LOW_BS: begin
            if (b != CH_BSLASH || fin) begin
               fail = 1'b1; fail_st = ST_NO_LOW;
            end else begin
               mode_in = MODE_LOW_U;
            end
         end
         MODE_LOW_U: begin
            if (b != CH_U || fin) begin
               fail = 1'b1; fail_st = ST_NO_LOW;
            end else begin
               pend_in = '0;
               acc_in  = '0;
               bad_in  = 1'b0;
               mode_in = MODE_HEX_LO;
            end
         end
         default: begin
            // Discarding until the end of the buffer.
         end
      endcase

      if (fail) begin
         mode_in = MODE_DONE;
      end
      term = fin && (mode_in != MODE_DONE);

      run_data.has_cp = emit;
      run_data.cp     = cp;
      run_data.has_st = fail | term;
      run_data.st     = fail ? fail_st : ST_UNTERM;
      run_valid       = accept & (emit | fail | term);

      // The end of a buffer starts a fresh string.
      if (fin) begin
         mode_in = MODE_PLAIN;
         pend_in = '0;
         acc_in  = '0;
         high_in = '0;
         lead_in = '0;
         bad_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         pend_ff <= '0;
         acc_ff  <= '0;
         high_ff <= '0;
         lead_ff <= '0;
         bad_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         acc_ff  <= acc_in;
         high_ff <= high_in;
         lead_ff <= lead_in;
         bad_ff  <= bad_in;
      end
   end

endmodule

// ===== rtl/core/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_queue: run queue
// A small first-in first-out queue of run records between parser and
// serializer.
// ----------------------------------------------------------------------------
module jsu_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  jsu_pkg::run_type wr_data,
   output logic             full,
   input  logic             rd_en,
   output jsu_pkg::run_type rd_data,
   output logic             empty
);
   import jsu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   run_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr, do_rd;

   always_comb begin
      full    = (count_ff == CNT_W'(DEPTH));
      empty   = (count_ff == '0);
      do_wr   = wr_en & ~full;
      do_rd   = rd_en & ~empty;
      rd_data = slot_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/core/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back: result serializer
// Encodes the code point of the head run as UTF-8 and presents its bytes and
// its status one result at a time.
// ----------------------------------------------------------------------------
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  jsu_pkg::run_type head,
   input  logic             q_empty,
   output logic             q_pop,
   input  logic             pop,
   output logic             empty,
   output jsu_pkg::rsp_type rsp_payload
);
   import jsu_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic [2:0] nbytes;
   logic [2:0] total;
   logic       is_st;
   logic       last;
   logic [7:0] enc [4];
   logic       take;

   always_comb begin
      enc[0] = head.cp[7:0];
      enc[1] = '0;
      enc[2] = '0;
      enc[3] = '0;
      if (!head.has_cp) begin
         nbytes = 3'd0;
      end else if (head.cp <= 21'h7f) begin
         nbytes = 3'd1;
      end else if (head.cp <= 21'h7ff) begin
         nbytes = 3'd2;
         enc[0] = {3'b110, head.cp[10:6]};
         enc[1] = {2'b10, head.cp[5:0]};
      end else if (head.cp <= 21'hffff) begin
         nbytes = 3'd3;
         enc[0] = {4'b1110, head.cp[15:12]};
         enc[1] = {2'b10, head.cp[11:6]};
         enc[2] = {2'b10, head.cp[5:0]};
      end else begin
         nbytes = 3'd4;
         enc[0] = {5'b11110, head.cp[20:18]};
         enc[1] = {2'b10, head.cp[17:12]};
         enc[2] = {2'b10, head.cp[11:6]};
         enc[3] = {2'b10, head.cp[5:0]};
      end

      total = nbytes + {2'b00, head.has_st};
      is_st = (idx_ff == nbytes);
      last  = (idx_ff == total - 3'd1);

      empty                = q_empty;
      rsp_payload.out_byte = is_st ? 8'h00 : enc[idx_ff[1:0]];
      rsp_payload.status   = is_st ? head.st : ST_BYTE;
      rsp_payload.run_last = last;

      take   = pop & ~q_empty;
      q_pop  = take & last;
      idx_in = idx_ff;
      if (take) begin
         idx_in = last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== rtl/core/json_string_unescape_utf8_unit.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit: JSON string body unescaper with UTF-8 check
// The results of a byte, if any, are written into the run queue at its transfer
// and shown from there. One input byte per cycle while full is low; one result
// per cycle on the output while pop is high. full rises while the run queue
// holds QUEUE_DEPTH runs; a run holds its slot until its last result is taken.
// Reset (synchronous): parser back to the plain string body, queue emptied.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  jsu_pkg::req_type req_payload,
   output logic             empty,
   input  logic             pop,
   output jsu_pkg::rsp_type rsp_payload
);
   import jsu_pkg::*;

   // The front end parses one byte per transfer and turns everything that the
   // byte causes into one run record: an optional code point and an optional
   // status. The back end expands the head record into its UTF-8 bytes and
   // the status. Raw UTF-8 sequences are carried as their code point too: the
   // parser has already rejected overlong forms, so re-encoding the code point
   // gives back exactly the bytes that arrived.

   logic    accept;
   logic    run_valid;
   run_type run_data;
   run_type head;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;

   // An input transfer needs a free queue slot only; a run that produces no
   // result is never written.
   assign accept = push & ~q_full;
   assign full   = q_full;

   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_payload (req_payload),
      .run_valid   (run_valid),
      .run_data    (run_data)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (run_valid),
      .wr_data (run_data),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (head),
      .empty   (q_empty)
   );

   // The serializer releases the queue slot on the transfer of the run's
   // last result.
   jsu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .pop         (pop),
      .empty       (empty),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/core/jsu_checker.sv =====
// ----------------------------------------------------------------------------
// jsu_checker: port-level checks of the unescaper
// Watches the result channel for run framing and status encoding.
// ----------------------------------------------------------------------------
module jsu_checker (
   input logic             clock,
   input logic             reset,
   input logic             empty,
   input logic             pop,
   input jsu_pkg::rsp_type rsp_payload
);
   import jsu_pkg::*;

   // A status result carries no byte.
   a_status_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_payload.status != ST_BYTE) |-> (rsp_payload.out_byte == 8'h00))
      else $error("status result carries a nonzero byte");

   // A status always closes the run of its input byte.
   a_status_ends_run: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_payload.status != ST_BYTE) |-> rsp_payload.run_last)
      else $error("status result is not the last of its run");

   // A UTF-8 lead byte is always followed by continuation bytes in its run.
   a_lead_not_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_payload.status == ST_BYTE && rsp_payload.out_byte[7:6] == 2'b11)
      |-> !rsp_payload.run_last)
      else $error("run ends on a UTF-8 lead byte");

   // The result side comes out of reset with nothing to show.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("results shown right after reset");

   // A result that is not taken stays in place.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_payload)))
      else $error("waiting result changed before its transfer");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (
   .clock       (clock),
   .reset       (reset),
   .empty       (empty),
   .pop         (pop),
   .rsp_payload (rsp_payload)
);

// ===== bench/json_unescape_check.sv =====
// ----------------------------------------------------------------------------
// json_unescape_check: result predictor and comparator for the unescaper
// Watches both queue-style channels of the block, predicts the results of
// each input transfer from its own copy of the parser state, and compares
// every result transfer with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module json_unescape_check
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  req_type     req_payload,
   input  logic        empty,
   input  logic        pop,
   input  rsp_type     rsp_payload,
   output int unsigned fail_count,
   output int unsigned outstanding
);

   localparam int MAX_RUN          = 5;
   localparam int SHOWN_MISMATCHES = 10;

   // Parser state as the block should hold it.
   mode_type    pmode;
   logic [2:0]  unit_count;
   logic [20:0] cp_accum;
   logic [9:0]  hi_bits;
   logic [7:0]  lead_bytes [3];
   logic [1:0]  cont_needed;
   logic        bad_unit;

   rsp_type     run_buf [MAX_RUN];
   int          run_len;
   rsp_type     decoded_due [$];
   int unsigned n_fail = 0;

   task automatic clear_parser();
      pmode         = MODE_PLAIN;
      unit_count    = '0;
      cp_accum      = '0;
      hi_bits       = '0;
      lead_bytes[0] = '0;
      lead_bytes[1] = '0;
      lead_bytes[2] = '0;
      cont_needed   = '0;
      bad_unit      = 1'b0;
   endtask

   task automatic put_result(input logic [7:0] value, input logic [3:0] st);
      rsp_type r;
      r.out_byte = value;
      r.status   = st;
      r.run_last = 1'b0;
      if (run_len < MAX_RUN) begin
         run_buf[run_len] = r;
         run_len++;
      end
   endtask

   // An error or the closing quote ends the string; later bytes are dropped.
   task automatic end_string(input logic [3:0] st);
      put_result(8'h00, st);
      pmode = MODE_DONE;
   endtask

   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      logic [7:0] t;
      if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
      if (c >= "a" && c <= "f") begin
         t = c - 8'h57;
         return t[4:0];
      end
      if (c >= "A" && c <= "F") begin
         t = c - 8'h37;
         return t[4:0];
      end
      return 5'd16;
   endfunction

   task automatic put_code_point(input logic [20:0] cp);
      if (cp <= 21'h7f) begin
         put_result(cp[7:0], ST_BYTE);
      end else if (cp <= 21'h7ff) begin
         put_result({3'b110, cp[10:6]}, ST_BYTE);
         put_result({2'b10, cp[5:0]}, ST_BYTE);
      end else if (cp <= 21'hffff) begin
         put_result({4'b1110, cp[15:12]}, ST_BYTE);
         put_result({2'b10, cp[11:6]}, ST_BYTE);
         put_result({2'b10, cp[5:0]}, ST_BYTE);
      end else begin
         put_result({5'b11110, cp[20:18]}, ST_BYTE);
         put_result({2'b10, cp[17:12]}, ST_BYTE);
         put_result({2'b10, cp[11:6]}, ST_BYTE);
         put_result({2'b10, cp[5:0]}, ST_BYTE);
      end
   endtask

   task automatic unescape_byte(input logic [7:0] b, input logic fin);
      logic [4:0]  d;
      logic [20:0] floor_cp;
      int          idx;
      int          i;
      rsp_type     r;
      run_len = 0;
      case (pmode)
         MODE_PLAIN: begin
            if (b == "\"") end_string(ST_CLOSED);
            else if (b < 8'h20) end_string(ST_CONTROL);
            else if (b == "\\") begin
               if (fin) end_string(ST_SHORT_ESC);
               else pmode = MODE_ESC;
            end else if (b < 8'h80) put_result(b, ST_BYTE);
            else if (b < 8'hc2 || b > 8'hf4) end_string(ST_BAD_UTF8);
            else begin
               cont_needed = (b <= 8'hdf) ? 2'd1 : (b <= 8'hef) ? 2'd2 : 2'd3;
               case (cont_needed)
                  2'd1:    cp_accum = {16'b0, b[4:0]};
                  2'd2:    cp_accum = {17'b0, b[3:0]};
                  default: cp_accum = {18'b0, b[2:0]};
               endcase
               lead_bytes[0] = b;
               unit_count    = '0;
               bad_unit      = 1'b0;
               if (fin) end_string(ST_SHORT_UTF8);
               else pmode = MODE_UTF8;
            end
         end
         MODE_UTF8: begin
            if (b[7:6] != 2'b10) bad_unit = 1'b1;
            cp_accum   = {cp_accum[14:0], b[5:0]};
            unit_count = unit_count + 3'd1;
            if (cont_needed == 2'd0) cont_needed = 2'd3;
            if (unit_count < {1'b0, cont_needed}) begin
               idx = (unit_count[1:0] == 2'd0) ? 0 :
                     (unit_count < 3'd3) ? int'(unit_count) : 2;
               lead_bytes[idx] = b;
               if (fin) end_string(ST_SHORT_UTF8);
            end else begin
               floor_cp = (cont_needed == 2'd1) ? 21'h80 :
                          (cont_needed == 2'd2) ? 21'h800 : 21'h10000;
               if (bad_unit || cp_accum < floor_cp || cp_accum > 21'h10ffff ||
                   (cp_accum >= 21'hd800 && cp_accum <= 21'hdfff)) begin
                  end_string(ST_BAD_UTF8);
               end else begin
                  for (i = 0; i < cont_needed; i++) put_result(lead_bytes[i], ST_BYTE);
                  put_result(b, ST_BYTE);
                  pmode = MODE_PLAIN;
               end
            end
         end
         MODE_ESC: begin
            pmode = MODE_PLAIN;
            case (b)
               "\"", "\\", "/": put_result(b, ST_BYTE);
               "b": put_result(8'h08, ST_BYTE);
               "f": put_result(8'h0c, ST_BYTE);
               "n": put_result(8'h0a, ST_BYTE);
               "r": put_result(8'h0d, ST_BYTE);
               "t": put_result(8'h09, ST_BYTE);
               "u": begin
                  unit_count = '0;
                  cp_accum   = '0;
                  bad_unit   = 1'b0;
                  if (fin) end_string(ST_SHORT_HEX);
                  else pmode = MODE_HEX_HI;
               end
               default: end_string(ST_BAD_ESC);
            endcase
         end
         MODE_HEX_HI, MODE_HEX_LO: begin
            d = nibble_of(b);
            if (d[4]) bad_unit = 1'b1;
            cp_accum   = {5'b0, cp_accum[11:0], d[3:0]};
            unit_count = unit_count + 3'd1;
            if (unit_count < 3'd4) begin
               if (fin) end_string((pmode == MODE_HEX_HI) ? ST_SHORT_HEX : ST_NO_LOW);
            end else if (bad_unit) begin
               end_string(ST_BAD_HEX);
            end else if (pmode == MODE_HEX_HI) begin
               if (cp_accum >= 21'hd800 && cp_accum <= 21'hdbff) begin
                  hi_bits = cp_accum[9:0];
                  if (fin) end_string(ST_NO_LOW);
                  else pmode = MODE_LOW_BS;
               end else if (cp_accum >= 21'hdc00 && cp_accum <= 21'hdfff) begin
                  end_string(ST_LONE_LOW);
               end else begin
                  put_code_point(cp_accum);
                  pmode = MODE_PLAIN;
               end
            end else begin
               if (cp_accum < 21'hdc00 || cp_accum > 21'hdfff) begin
                  end_string(ST_BAD_LOW);
               end else begin
                  put_code_point(21'h10000 + {hi_bits, cp_accum[9:0]});
                  pmode = MODE_PLAIN;
               end
            end
         end
         MODE_LOW_BS: begin
            if (b != "\\" || fin) end_string(ST_NO_LOW);
            else pmode = MODE_LOW_U;
         end
         MODE_LOW_U: begin
            if (b != "u" || fin) begin
               end_string(ST_NO_LOW);
            end else begin
               unit_count = '0;
               cp_accum   = '0;
               bad_unit   = 1'b0;
               pmode      = MODE_HEX_LO;
            end
         end
         default: ;
      endcase
      if (fin) begin
         if (pmode != MODE_DONE) put_result(8'h00, ST_UNTERM);
         clear_parser();
      end
      for (i = 0; i < run_len; i++) begin
         r = run_buf[i];
         r.run_last = (i == run_len - 1);
         decoded_due.insert(decoded_due.size(), r);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         clear_parser();
         decoded_due.delete();
      end else begin
         // A result leaves only after its input has been written into the run queue, so
         // the result side is handled before the input of the same edge.
         if (pop && !empty) begin
            if (decoded_due.size() == 0) begin
               n_fail++;
               if (n_fail <= SHOWN_MISMATCHES)
                  $display("%0t unexpected result: byte %02h status %0d last %0b", $time,
                           rsp_payload.out_byte, rsp_payload.status, rsp_payload.run_last);
            end else begin
               want = decoded_due.pop_front();
               if (want.out_byte !== rsp_payload.out_byte ||
                   want.status !== rsp_payload.status ||
                   want.run_last !== rsp_payload.run_last) begin
                  n_fail++;
                  if (n_fail <= SHOWN_MISMATCHES)
                     $display("%0t mismatch: want %02h/%0d/%0b got %02h/%0d/%0b",
                              $time, want.out_byte, want.status, want.run_last,
                              rsp_payload.out_byte, rsp_payload.status,
                              rsp_payload.run_last);
               end
            end
         end
         if (push && !full) begin
            unescape_byte(req_payload.byte_in, req_payload.final_byte);
         end
      end
      fail_count  <= n_fail;
      outstanding <= decoded_due.size();
   end

endmodule

// ===== bench/tb_json_string_unescape_utf8_unit.sv =====
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8_unit: testbench of the JSON string unescaper
// Feeds string bodies byte by byte, first a few hand-picked ones, then random
// strings built from well-formed units with some damage mixed in. Both sides
// stall at random; a separate module predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_json_string_unescape_utf8_unit;
   import jsu_pkg::*;

   // Input bytes sent in all, the hand-picked strings included; from
   // CALM_ITEMS on, neither side stalls at random.
   localparam int TOTAL_ITEMS  = 220;
   localparam int CALM_ITEMS   = 180;
   // The receiver stops once for this long after this many result transfers,
   // so that the run queue fills and full holds the sender back.
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 60;
   // Cycles without any transfer before the run is declared hung. Well above
   // the long hold plus the longest random stall on both sides.
   localparam int STALL_LIMIT  = 2000;
   // Quiet cycles after the last expected result; anything late from the block
   // shows up well within this.
   localparam int DRAIN_CYCLES = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push  = 1'b0;
   logic        pop   = 1'b0;
   req_type     req_payload = '0;
   logic        full;
   logic        empty;
   rsp_type     rsp_payload;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned sent_count   = 0;
   int unsigned pop_count    = 0;
   int unsigned stall_cycles = 0;
   bit          calm         = 1'b0;
   bit          hold_done    = 1'b0;

   // The string being assembled before it is sent.
   logic [7:0]  text_q [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   json_string_unescape_utf8_unit uut (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_payload (req_payload),
      .empty       (empty),
      .pop         (pop),
      .rsp_payload (rsp_payload)
   );

   json_unescape_check decode_check (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_payload (req_payload),
      .empty       (empty),
      .pop         (pop),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Watchdog: any transfer on either side restarts the count.
   always @(posedge clock) begin
      if (pop && !empty) pop_count <= pop_count + 1;
      if (reset || (push && !full) || (pop && !empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
         $display("[json_string_unescape_utf8_unit] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Receiver. pop changes only at the falling edge, once per edge at most.
   // Besides short random stalls it holds off once for a long stretch while
   // the sender keeps offering bytes.
   initial begin : receiver
      int gap;
      while (reset) @(posedge clock);
      forever begin
         @(negedge clock);
         if (!hold_done && pop_count >= HOLD_AFTER) begin
            pop = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            pop = 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap - 1) @(negedge clock);
         end else begin
            pop = 1'b1;
         end
      end
   end

   // Offer one byte and return at the rising edge of its transfer. push stays
   // high from one byte to the next unless a random gap is inserted first.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      @(negedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         push = 1'b0;
         gap  = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
      end
      push                    = 1'b1;
      req_payload.byte_in     = b;
      req_payload.final_byte  = fin;
      @(posedge clock);
      while (full) @(posedge clock);
      sent_count++;
   endtask

   // Queue one more byte of the string being assembled.
   task automatic append_byte(input logic [7:0] c);
      text_q.insert(text_q.size(), c);
   endtask

   // Send the assembled string; its last byte closes the input buffer.
   task automatic flush_string();
      int i;
      for (i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   task automatic add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) append_byte(s[i]);
   endtask

   function automatic bit is_hex(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [7:0] non_hex();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (is_hex(c));
      return c;
   endfunction

   // Hex digit in random letter case.
   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + v;
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
   endfunction

   // A \u escape; now and then one digit is spoiled.
   task automatic add_hex4(input logic [15:0] v);
      logic [7:0] d [4];
      int         i;
      for (i = 0; i < 4; i++) d[i] = hex_char(v[15 - 4*i -: 4]);
      if ($urandom_range(0, 9) == 0) d[2'($urandom_range(0, 3))] = non_hex();
      append_byte("\\");
      append_byte("u");
      for (i = 0; i < 4; i++) append_byte(d[i]);
   endtask

   task automatic add_ascii();
      logic [7:0] c;
      c = 8'($urandom_range(8'h20, 8'h7f));
      if (c == "\"" || c == "\\") c = "a";
      append_byte(c);
   endtask

   task automatic add_short_escape();
      string picks;
      picks = "\"\\/bfnrt";
      append_byte("\\");
      append_byte(picks[$urandom_range(0, 7)]);
   endtask

   // Plain code points, surrogate pairs, and the ways a pair can go wrong.
   task automatic add_u_escape();
      logic [15:0] hi;
      logic [15:0] lo;
      logic [15:0] v;
      logic [7:0]  c;
      hi = 16'hd800 + 16'($urandom_range(0, 16'h3ff));
      lo = 16'hdc00 + 16'($urandom_range(0, 16'h3ff));
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            v = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 16'h7ff))
                                            : 16'($urandom);
            if (v[15:11] == 5'b11011) v[15] = 1'b0;
            add_hex4(v);
         end
         4, 5, 6: begin
            add_hex4(hi);
            add_hex4(lo);
         end
         7: add_hex4(lo);
         8: begin
            // Second half present but not a low surrogate.
            add_hex4(hi);
            v = 16'($urandom);
            if (v >= 16'hdc00 && v <= 16'hdfff) v = v ^ 16'h2000;
            add_hex4(v);
         end
         default: begin
            // High half followed by something other than \u.
            add_hex4(hi);
            if ($urandom_range(0, 1)) begin
               c = 8'($urandom_range(0, 255));
               if (c == "\\") c = 8'h5d;
               append_byte(c);
            end else begin
               c = 8'($urandom_range(0, 255));
               if (c == "u") c = 8'h76;
               append_byte("\\");
               append_byte(c);
            end
         end
      endcase
   endtask

   // Raw multibyte sequence, mostly valid; a quarter are damaged: a bad
   // continuation byte, an overlong or surrogate or out-of-range form, or a
   // lead byte that can never start a sequence.
   task automatic add_utf8();
      logic [7:0]  u [4];
      logic [20:0] cp;
      int          len;
      int          i;
      len = $urandom_range(2, 4);
      case (len)
         2: begin
            cp   = 21'($urandom_range(21'h80, 21'h7ff));
            u[0] = {3'b110, cp[10:6]};
            u[1] = {2'b10, cp[5:0]};
         end
         3: begin
            cp = 21'($urandom_range(21'h800, 21'hffff));
            if (cp >= 21'hd800 && cp <= 21'hdfff) cp = cp ^ 21'h4000;
            u[0] = {4'b1110, cp[15:12]};
            u[1] = {2'b10, cp[11:6]};
            u[2] = {2'b10, cp[5:0]};
         end
         default: begin
            cp   = 21'($urandom_range(21'h10000, 21'h10ffff));
            u[0] = {5'b11110, cp[20:18]};
            u[1] = {2'b10, cp[17:12]};
            u[2] = {2'b10, cp[11:6]};
            u[3] = {2'b10, cp[5:0]};
         end
      endcase
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 2))
            0: u[2'($urandom_range(1, len - 1))] = 8'($urandom_range(0, 255));
            1: begin
               if (len == 2) begin
                  u[0] = 8'($urandom_range(8'hc0, 8'hc1));
               end else if (len == 3) begin
                  if ($urandom_range(0, 1)) begin
                     u[0] = 8'he0;
                     u[1] = 8'h80 + 8'($urandom_range(0, 31));
                  end else begin
                     u[0] = 8'hed;
                     u[1] = 8'ha0 + 8'($urandom_range(0, 31));
                  end
               end else begin
                  if ($urandom_range(0, 1)) begin
                     u[0] = 8'hf0;
                     u[1] = 8'h80 + 8'($urandom_range(0, 15));
                  end else begin
                     u[0] = 8'hf4;
                     u[1] = 8'h90 + 8'($urandom_range(0, 47));
                  end
               end
            end
            default: begin
               u[0] = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hc1))
                                           : 8'($urandom_range(8'hf5, 8'hff));
            end
         endcase
      end
      for (i = 0; i < len; i++) append_byte(u[i]);
   endtask

   // A random string body: a few units, sometimes a closing quote with some
   // trailing bytes, and sometimes cut short so the buffer may end mid-unit.
   task automatic build_random_string();
      int         units;
      int         r;
      int         cut;
      units = $urandom_range(1, 8);
      repeat (units) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            add_ascii();
         end else if (r < 50) begin
            add_short_escape();
         end else if (r < 68) begin
            add_u_escape();
         end else if (r < 88) begin
            add_utf8();
         end else if (r < 94) begin
            append_byte(8'($urandom_range(0, 255)));
         end else begin
            append_byte("\"");
            repeat ($urandom_range(0, 2)) append_byte(8'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 4) == 0 && text_q.size() > 1) begin
         cut = $urandom_range(1, text_q.size() - 1);
         if (cut > 3) cut = 3;
         repeat (cut) text_q.delete(text_q.size() - 1);
      end
   endtask

   initial begin : stimulus
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Hand-picked strings, each ending its own input buffer.
      // Closing quote, then a byte that must be dropped without a result.
      add_text("\"x");
      flush_string();
      // Lowest byte value is a control character.
      append_byte(8'h00);
      flush_string();
      // Highest byte value can never lead a sequence.
      append_byte(8'hff);
      flush_string();
      // Buffer ends right after a backslash.
      add_text("\\");
      flush_string();
      // Bad hex digit, but the buffer runs out first: the shortfall wins.
      add_text("\\uG");
      flush_string();
      // Bad continuation byte, again reported as a shortfall.
      append_byte(8'hf4);
      append_byte(8'h41);
      flush_string();
      // Highest code point from a pair: four bytes plus the unterminated mark.
      add_text("\\udbff\\udfff");
      flush_string();
      // High half not followed by a backslash.
      add_text("\\ud800x");
      flush_string();
      // Unknown escape letter.
      add_text("\\q");
      flush_string();
      // Low half on its own.
      add_text("\\udc00");
      flush_string();
      // Second half that is not a low surrogate.
      add_text("\\ud800\\u0041");
      flush_string();

      // Random strings until enough bytes have been sent.
      while (sent_count < TOTAL_ITEMS) begin
         if (sent_count >= CALM_ITEMS) calm = 1'b1;
         build_random_string();
         flush_string();
      end

      @(negedge clock);
      push = 1'b0;

      // Let the expected results drain, then watch for stragglers.
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("[json_string_unescape_utf8_unit] OK");
      end else begin
         $display("[json_string_unescape_utf8_unit] ERROR");
      end
      $finish;
   end

endmodule

// ===== json_string_unescape_utf8_unit.f =====
rtl/core/jsu_pkg.sv
rtl/core/jsu_front.sv
rtl/core/jsu_queue.sv
rtl/core/jsu_back.sv
rtl/core/json_string_unescape_utf8_unit.sv
rtl/core/jsu_checker.sv
bench/json_unescape_check.sv
bench/tb_json_string_unescape_utf8_unit.sv
